### rtl/local_date_to_epoch_seconds_macros.svh
// Assertion macros shared by the date conversion RTL.
`ifndef LOCAL_DATE_TO_EPOCH_SECONDS_MACROS_SVH
`define LOCAL_DATE_TO_EPOCH_SECONDS_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define LDES_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define LDES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ldes_pkg.sv
// Types, constants, tables and microprogram for the date to epoch converter.
package ldes_pkg;

  // Field widths of the request, result and zone register
  localparam int SEC_W   = 11;
  localparam int MIN_W   = 11;
  localparam int HOUR_W  = 10;
  localparam int MDAY_W  = 10;
  localparam int MON_W   = 7;
  localparam int YEAR_W  = 8;
  localparam int EPOCH_W = 41;
  localparam int ZONE_W  = 17;

  // Arithmetic constants
  localparam int SECONDS_PER_HOUR           = 3600;
  localparam int DAYS_PER_QUAD              = 1461;
  localparam int DAYS_PER_YEAR              = 365;
  localparam int DAYS_1900_TO_1970_PLUS_ONE = 25568;
  localparam int LEAP_CENTURY               = 400;

  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_DIV_EST,
    OP_DIV_FIX,
    OP_WALK_DN,
    OP_WALK_UP,
    OP_QUAD,
    OP_DAYS,
    OP_MAC24,
    OP_MAC60,
    OP_ZONE,
    OP_DONE,
    OP_FAIL
  } op_t;

  typedef enum logic [1:0] {
    SEL_SEC,
    SEL_MIN,
    SEL_HOUR,
    SEL_MON
  } sel_t;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_MDAY_LOW,
    COND_MDAY_HIGH,
    COND_YEAR_BAD
  } cond_t;

  // One microcode word
  typedef struct packed {
    op_t   op;
    sel_t  sel;
    cond_t cond;
    pc_t   target;
    logic  last;
  } uword_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic mday_low;
    logic mday_high;
    logic year_bad;
  } flags_t;

  // One request item
  typedef struct packed {
    logic signed [SEC_W-1:0]  second_value;
    logic signed [MIN_W-1:0]  minute_value;
    logic signed [HOUR_W-1:0] hour_value;
    logic signed [MDAY_W-1:0] day_of_month;
    logic signed [MON_W-1:0]  month_index;
    logic [YEAR_W-1:0]        years_since_1900;
    logic                     dst_active;
  } item_t;

  // Jump targets in the microprogram
  localparam pc_t PC_START   = 5'd0;
  localparam pc_t PC_WALK_DN = 5'd8;
  localparam pc_t PC_WALK_UP = 5'd9;
  localparam pc_t PC_FAIL    = 5'd18;

  // Divisor of each carry step
  function automatic logic [5:0] div_base(sel_t s);
    case (s)
      SEL_SEC:  return 6'd60;
      SEL_MIN:  return 6'd60;
      SEL_HOUR: return 6'd24;
      SEL_MON:  return 6'd12;
      default:  return 6'd60;
    endcase
  endfunction

  // Reciprocal of the divisor scaled by 2^16, rounded down
  function automatic logic [12:0] div_recip(sel_t s);
    case (s)
      SEL_SEC:  return 13'd1092;
      SEL_MIN:  return 13'd1092;
      SEL_HOUR: return 13'd2730;
      SEL_MON:  return 13'd5461;
      default:  return 13'd1092;
    endcase
  endfunction

  // Quotient bias that makes the biased operand nonnegative
  function automatic logic [4:0] div_bias_q(sel_t s);
    case (s)
      SEL_SEC:  return 5'd18;
      SEL_MIN:  return 5'd18;
      SEL_HOUR: return 5'd23;
      SEL_MON:  return 5'd6;
      default:  return 5'd18;
    endcase
  endfunction

  // Bias added to the operand: divisor times quotient bias
  function automatic logic [11:0] div_bias(sel_t s);
    case (s)
      SEL_SEC:  return 12'd1080;
      SEL_MIN:  return 12'd1080;
      SEL_HOUR: return 12'd552;
      SEL_MON:  return 12'd72;
      default:  return 12'd1080;
    endcase
  endfunction

  // Leap rule for years counted from 1900; the normalized span only
  // reaches centuries at 1900, 2000 and 2100.
  function automatic logic is_leap(logic signed [9:0] y);
    return (y[1:0] == 2'b00) && (y != 10'sd0) && (y != 10'sd200);
  endfunction

  function automatic logic [4:0] month_len(logic signed [9:0] y, logic [3:0] m);
    case (m)
      4'd0:    return 5'd31;
      4'd1:    return is_leap(y) ? 5'd29 : 5'd28;
      4'd2:    return 5'd31;
      4'd3:    return 5'd30;
      4'd4:    return 5'd31;
      4'd5:    return 5'd30;
      4'd6:    return 5'd31;
      4'd7:    return 5'd31;
      4'd8:    return 5'd30;
      4'd9:    return 5'd31;
      4'd10:   return 5'd30;
      4'd11:   return 5'd31;
      default: return 5'd31;
    endcase
  endfunction

  function automatic logic [8:0] days_before(logic [3:0] m);
    case (m)
      4'd0:    return 9'd0;
      4'd1:    return 9'd31;
      4'd2:    return 9'd59;
      4'd3:    return 9'd90;
      4'd4:    return 9'd120;
      4'd5:    return 9'd151;
      4'd6:    return 9'd181;
      4'd7:    return 9'd212;
      4'd8:    return 9'd243;
      4'd9:    return 9'd273;
      4'd10:   return 9'd304;
      4'd11:   return 9'd334;
      default: return 9'd0;
    endcase
  endfunction

  // Days into a four year group: r * 365, plus one past the leap year
  function automatic logic [10:0] year_days(logic [1:0] r);
    case (r)
      2'd0:    return 11'd0;
      2'd1:    return 11'(DAYS_PER_YEAR + 1);
      2'd2:    return 11'(2 * DAYS_PER_YEAR + 1);
      2'd3:    return 11'(3 * DAYS_PER_YEAR + 1);
      default: return 11'd0;
    endcase
  endfunction

  function automatic uword_t uw(op_t op, sel_t sel, cond_t cond, pc_t target, logic last);
    uword_t w;
    w.op     = op;
    w.sel    = sel;
    w.cond   = cond;
    w.target = target;
    w.last   = last;
    return w;
  endfunction

  // Microprogram
  function automatic uword_t ucode(pc_t pc);
    case (pc)
      5'd0:    return uw(OP_DIV_EST, SEL_SEC,  COND_NEVER,     PC_START,   1'b0);
      5'd1:    return uw(OP_DIV_FIX, SEL_SEC,  COND_NEVER,     PC_START,   1'b0);
      5'd2:    return uw(OP_DIV_EST, SEL_MIN,  COND_NEVER,     PC_START,   1'b0);
      5'd3:    return uw(OP_DIV_FIX, SEL_MIN,  COND_NEVER,     PC_START,   1'b0);
      5'd4:    return uw(OP_DIV_EST, SEL_HOUR, COND_NEVER,     PC_START,   1'b0);
      5'd5:    return uw(OP_DIV_FIX, SEL_HOUR, COND_NEVER,     PC_START,   1'b0);
      5'd6:    return uw(OP_DIV_EST, SEL_MON,  COND_NEVER,     PC_START,   1'b0);
      5'd7:    return uw(OP_DIV_FIX, SEL_MON,  COND_NEVER,     PC_START,   1'b0);
      5'd8:    return uw(OP_WALK_DN, SEL_SEC,  COND_MDAY_LOW,  PC_WALK_DN, 1'b0);
      5'd9:    return uw(OP_WALK_UP, SEL_SEC,  COND_MDAY_HIGH, PC_WALK_UP, 1'b0);
      5'd10:   return uw(OP_NOP,     SEL_SEC,  COND_YEAR_BAD,  PC_FAIL,    1'b0);
      5'd11:   return uw(OP_QUAD,    SEL_SEC,  COND_NEVER,     PC_START,   1'b0);
      5'd12:   return uw(OP_DAYS,    SEL_SEC,  COND_NEVER,     PC_START,   1'b0);
      5'd13:   return uw(OP_MAC24,   SEL_HOUR, COND_NEVER,     PC_START,   1'b0);
      5'd14:   return uw(OP_MAC60,   SEL_MIN,  COND_NEVER,     PC_START,   1'b0);
      5'd15:   return uw(OP_MAC60,   SEL_SEC,  COND_NEVER,     PC_START,   1'b0);
      5'd16:   return uw(OP_ZONE,    SEL_SEC,  COND_NEVER,     PC_START,   1'b0);
      5'd17:   return uw(OP_DONE,    SEL_SEC,  COND_NEVER,     PC_START,   1'b1);
      5'd18:   return uw(OP_FAIL,    SEL_SEC,  COND_NEVER,     PC_START,   1'b1);
      default: return uw(OP_FAIL,    SEL_SEC,  COND_NEVER,     PC_START,   1'b1);
    endcase
  endfunction

endpackage

### rtl/ldes_if.sv
// Channel interfaces: request, result and zone register write.
interface ldes_req_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ldes_pkg::SEC_W-1:0]     second_value;
  logic signed [ldes_pkg::MIN_W-1:0]     minute_value;
  logic signed [ldes_pkg::HOUR_W-1:0]    hour_value;
  logic signed [ldes_pkg::MDAY_W-1:0]    day_of_month;
  logic signed [ldes_pkg::MON_W-1:0]     month_index;
  logic [ldes_pkg::YEAR_W-1:0]           years_since_1900;
  logic                                  dst_active;

  modport source (
    output valid, second_value, minute_value, hour_value, day_of_month,
           month_index, years_since_1900, dst_active,
    input  ready
  );
  modport sink (
    input  valid, second_value, minute_value, hour_value, day_of_month,
           month_index, years_since_1900, dst_active,
    output ready
  );
endinterface

interface ldes_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ldes_pkg::EPOCH_W-1:0]   epoch_seconds;
  logic                                  range_error;

  modport source (output valid, epoch_seconds, range_error, input ready);
  modport sink (input valid, epoch_seconds, range_error, output ready);
endinterface

interface ldes_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ldes_pkg::ZONE_W-1:0]    zone_offset_seconds;

  modport source (output valid, zone_offset_seconds, input ready);
  modport sink (input valid, zone_offset_seconds, output ready);
endinterface

### rtl/local_date_to_epoch_seconds.sv
// Top level: local broken-down time to epoch seconds converter.
// Takes one request with possibly out-of-range second, minute, hour, day,
// month, year-since-1900 and DST flag, normalizes it and returns seconds
// since 1970-01-01 UTC plus the zone offset register (plus one hour under
// DST), or range_error with zero when the normalized year is outside
// 1901..2099. A microcoded sequencer drives one datapath step per cycle and
// holds the final step while the result register is full: eight steps
// normalize seconds, minutes, hours and months by reciprocal division, the
// day-of-month walk then moves one month per cycle, and the remaining steps
// count days and accumulate seconds. The month walk sets how long a request
// takes; a range error ends it early. A new request is taken once the
// previous one has reached the result register, which holds it until taken.
// The zone register may be written only while no request is in progress.
`include "local_date_to_epoch_seconds_macros.svh"

module local_date_to_epoch_seconds (
  input logic        clk,
  input logic        rst,
  ldes_req_if.sink   request,
  ldes_rsp_if.source result,
  ldes_cfg_if.sink   cfg
);
  import ldes_pkg::*;

  logic signed [ZONE_W-1:0]  zone;
  item_t                     item;
  uword_t                    ctrl;
  flags_t                    flags;
  logic                      busy;
  logic                      start;
  logic                      out_free;
  logic                      load_out;
  logic signed [EPOCH_W-1:0] acc;
  logic                      rsp_valid;
  logic signed [EPOCH_W-1:0] epoch;
  logic                      err;

  // Take a request whenever the sequencer is idle
  assign request.ready = !busy;
  assign start         = request.valid && !busy;
  assign cfg.ready     = 1'b1;

  always_comb begin
    item.second_value     = request.second_value;
    item.minute_value     = request.minute_value;
    item.hour_value       = request.hour_value;
    item.day_of_month     = request.day_of_month;
    item.month_index      = request.month_index;
    item.years_since_1900 = request.years_since_1900;
    item.dst_active       = request.dst_active;
  end

  // Zone offset register
  always_ff @(posedge clk) begin
    if (rst) begin
      zone <= '0;
    end else if (cfg.valid) begin
      zone <= cfg.zone_offset_seconds;
    end
  end

  ldes_useq u_useq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .flags    (flags),
    .ctrl     (ctrl),
    .busy     (busy)
  );

  ldes_dpath u_dpath (
    .clk   (clk),
    .rst   (rst),
    .en    (busy),
    .load  (start),
    .item  (item),
    .zone  (zone),
    .ctrl  (ctrl),
    .flags (flags),
    .acc   (acc)
  );

  // Result register
  assign out_free = !rsp_valid || result.ready;
  assign load_out = busy && ctrl.last && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (result.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      epoch <= (ctrl.op == OP_FAIL) ? '0 : acc;
      err   <= (ctrl.op == OP_FAIL);
    end
  end

  assign result.valid         = rsp_valid;
  assign result.epoch_seconds = epoch;
  assign result.range_error   = err;

  `LDES_ASSERT_NEXT(a_start_busy, clk, rst, start, busy, "accepted request did not start the sequencer")
  `LDES_ASSERT_SAME(a_err_zero, clk, rst, rsp_valid && err, epoch == '0, "range error result carries nonzero seconds")

endmodule

### rtl/ldes_useq.sv
// Microcode sequencer: step counter, program table and conditional jumps.
`include "local_date_to_epoch_seconds_macros.svh"

module ldes_useq (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            out_free,
  input  ldes_pkg::flags_t flags,
  output ldes_pkg::uword_t ctrl,
  output logic            busy
);
  import ldes_pkg::*;

  pc_t  pc;
  pc_t  pc_next;
  logic busy_next;
  logic hit;

  // Fetch the control word and pick the next step
  always_comb begin
    ctrl = ucode(pc);
    case (ctrl.cond)
      COND_NEVER:     hit = 1'b0;
      COND_MDAY_LOW:  hit = flags.mday_low;
      COND_MDAY_HIGH: hit = flags.mday_high;
      COND_YEAR_BAD:  hit = flags.year_bad;
      default:        hit = 1'b0;
    endcase

    pc_next   = pc;
    busy_next = busy;
    if (start) begin
      pc_next   = PC_START;
      busy_next = 1'b1;
    end else if (busy) begin
      if (ctrl.last) begin
        // Hold on the final step until the result register is free
        if (out_free) begin
          pc_next   = PC_START;
          busy_next = 1'b0;
        end
      end else if (hit) begin
        pc_next = ctrl.target;
      end else begin
        pc_next = pc + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= PC_START;
      busy <= 1'b0;
    end else begin
      pc   <= pc_next;
      busy <= busy_next;
    end
  end

  `LDES_ASSERT_NEXT(a_pc_advance, clk, rst, busy && !ctrl.last && ctrl.cond == COND_NEVER, pc == $past(pc) + 1'b1, "step counter did not advance on a plain step")

endmodule

### rtl/ldes_dpath.sv
// Datapath: field registers, reciprocal divider, month walker and accumulator.
`include "local_date_to_epoch_seconds_macros.svh"

module ldes_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                load,
  input  ldes_pkg::item_t                     item,
  input  logic signed [ldes_pkg::ZONE_W-1:0]  zone,
  input  ldes_pkg::uword_t                    ctrl,
  output ldes_pkg::flags_t                    flags,
  output logic signed [ldes_pkg::EPOCH_W-1:0] acc
);
  import ldes_pkg::*;

  // Working fields, wide enough for the carries they take
  logic signed [SEC_W-1:0]  sec;
  logic signed [MIN_W:0]    min;
  logic signed [HOUR_W:0]   hour;
  logic signed [MDAY_W:0]   mday;
  logic signed [MON_W-1:0]  mon;
  logic signed [YEAR_W+1:0] year;
  logic                     dst;
  logic [5:0]               qest;

  logic [11:0]              opnd;
  logic [11:0]              vb;
  logic [24:0]              prod;
  logic [11:0]              qd;
  logic [11:0]              r0;
  logic                     fix;
  logic [6:0]               rem;
  logic [6:0]               qfix;
  logic signed [7:0]        carry;
  logic [3:0]               mon4;
  logic [3:0]               mon_dn;
  logic [3:0]               mon_up;
  logic signed [YEAR_W+1:0] year_dn;
  logic signed [YEAR_W+1:0] year_up;
  logic [4:0]               len_dn;
  logic [4:0]               len_cur;
  logic [16:0]              quad_days;
  logic                     leap_adj;
  logic signed [EPOCH_W-1:0] days_sum;
  logic signed [EPOCH_W-1:0] sec_ext;
  logic signed [EPOCH_W-1:0] min_ext;
  logic signed [EPOCH_W-1:0] hour_ext;
  logic signed [EPOCH_W-1:0] zone_ext;

  // Divider: biased operand, reciprocal estimate and one correction
  always_comb begin
    case (ctrl.sel)
      SEL_SEC:  opnd = {sec[SEC_W-1], sec};
      SEL_MIN:  opnd = min;
      SEL_HOUR: opnd = {hour[HOUR_W], hour};
      SEL_MON:  opnd = {{5{mon[MON_W-1]}}, mon};
      default:  opnd = '0;
    endcase
    vb    = opnd + div_bias(ctrl.sel);
    prod  = 25'(vb) * 25'(div_recip(ctrl.sel));
    qd    = 12'(qest) * 12'(div_base(ctrl.sel));
    r0    = vb - qd;
    fix   = (r0 >= 12'(div_base(ctrl.sel)));
    rem   = fix ? 7'(r0 - 12'(div_base(ctrl.sel))) : 7'(r0);
    qfix  = 7'(qest) + 7'(fix);
    carry = $signed({1'b0, qfix}) - $signed({3'b000, div_bias_q(ctrl.sel)});
  end

  // Month walker: one month per step in either direction
  always_comb begin
    mon4    = mon[3:0];
    mon_dn  = (mon4 == 4'd0) ? 4'd11 : mon4 - 4'd1;
    year_dn = (mon4 == 4'd0) ? year - 10'sd1 : year;
    len_dn  = month_len(year_dn, mon_dn);
    len_cur = month_len(year, mon4);
    mon_up  = (mon4 == 4'd11) ? 4'd0 : mon4 + 4'd1;
    year_up = (mon4 == 4'd11) ? year + 10'sd1 : year;

    flags.mday_low  = (mday < 11'sd1);
    flags.mday_high = (mday > $signed({6'b000000, len_cur}));
    flags.year_bad  = (year < 10'sd1) || (year > 10'sd199);
  end

  // Day count and second accumulation terms
  always_comb begin
    quad_days = 17'(year[7:2]) * 17'(DAYS_PER_QUAD);
    leap_adj  = (mon4 > 4'd1) && is_leap(year);
    days_sum  = acc + 41'(year_days(year[1:0])) + 41'(days_before(mon4))
              + 41'(leap_adj) + {{30{mday[MDAY_W]}}, mday}
              - 41'(DAYS_1900_TO_1970_PLUS_ONE) - 41'd1;
    sec_ext   = {{30{sec[SEC_W-1]}}, sec};
    min_ext   = {{29{min[MIN_W]}}, min};
    hour_ext  = {{30{hour[HOUR_W]}}, hour};
    zone_ext  = {{24{zone[ZONE_W-1]}}, zone};
  end

  // Load a request, then execute one control word per cycle
  always_ff @(posedge clk) begin
    if (load) begin
      sec  <= item.second_value;
      min  <= {item.minute_value[MIN_W-1], item.minute_value};
      hour <= {item.hour_value[HOUR_W-1], item.hour_value};
      mday <= {item.day_of_month[MDAY_W-1], item.day_of_month};
      mon  <= item.month_index;
      year <= {2'b00, item.years_since_1900};
      dst  <= item.dst_active;
    end else if (en) begin
      case (ctrl.op)
        OP_DIV_EST: qest <= prod[21:16];
        OP_DIV_FIX: begin
          case (ctrl.sel)
            SEL_SEC: begin
              sec <= 11'(rem);
              min <= min + {{4{carry[7]}}, carry};
            end
            SEL_MIN: begin
              min  <= 12'(rem);
              hour <= hour + {{3{carry[7]}}, carry};
            end
            SEL_HOUR: begin
              hour <= 11'(rem);
              mday <= mday + {{3{carry[7]}}, carry};
            end
            SEL_MON: begin
              mon  <= rem;
              year <= year + {{2{carry[7]}}, carry};
            end
            default: begin
            end
          endcase
        end
        OP_WALK_DN: begin
          if (flags.mday_low) begin
            mday <= mday + {6'b000000, len_dn};
            mon  <= {3'b000, mon_dn};
            year <= year_dn;
          end
        end
        OP_WALK_UP: begin
          if (flags.mday_high) begin
            mday <= mday - {6'b000000, len_cur};
            mon  <= {3'b000, mon_up};
            year <= year_up;
          end
        end
        OP_QUAD:  acc <= {24'd0, quad_days};
        OP_DAYS:  acc <= days_sum;
        OP_MAC24: acc <= (acc <<< 4) + (acc <<< 3) + hour_ext;
        OP_MAC60: begin
          if (ctrl.sel == SEL_MIN) begin
            acc <= (acc <<< 6) - (acc <<< 2) + min_ext;
          end else begin
            acc <= (acc <<< 6) - (acc <<< 2) + sec_ext;
          end
        end
        OP_ZONE:  acc <= acc + zone_ext + (dst ? 41'(SECONDS_PER_HOUR) : 41'd0);
        default: begin
        end
      endcase
    end
  end

  `LDES_ASSERT_NEXT(a_sec_norm, clk, rst, en && !load && ctrl.op == OP_DIV_FIX && ctrl.sel == SEL_SEC, sec >= 0 && sec < 60, "seconds not normalized after carry")
  `LDES_ASSERT_SAME(a_mon_walk, clk, rst, en && (ctrl.op == OP_WALK_DN || ctrl.op == OP_WALK_UP), mon >= 0 && mon < 12, "month out of range while walking days")

endmodule
